// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the quadtree dither block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define QTD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check on every clock edge, reset included.
`define QTD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// File: src/qtd_pkg.sv
// ----------------------------------------------------------------------------
// qtd_pkg
// Types, constants and helper functions of the quadtree dither block.
// ----------------------------------------------------------------------------
package qtd_pkg;

    localparam int SIDE      = 64;
    localparam int LOG_SIDE  = $clog2(SIDE);
    localparam int NPIX      = SIDE * SIDE;
    localparam int PIX_W     = 2 * LOG_SIDE;
    localparam int SMP_W     = 16;
    localparam int BIAS      = 16384;
    localparam int NODES     = (NPIX - 1) / 3;
    localparam int NODE_W    = $clog2(NODES);
    localparam int SUM_W     = SMP_W + PIX_W;
    localparam int CNT_W     = PIX_W + 1;
    localparam int LVL_W     = $clog2(LOG_SIDE + 1);
    localparam int IDX_W     = PIX_W - 2;
    localparam int STEP_W    = 3;
    localparam int NUM_W     = CNT_W + SUM_W;
    localparam int DIV_STEPS = CNT_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);
    localparam int ROUND_SH  = 15;

    typedef enum logic [3:0] {
        S_IDLE,
        S_B_STEP,
        S_D_READ,
        S_D_ADD,
        S_D_MUL,
        S_D_DIV,
        S_D_CLAMP,
        S_D_WRITE
    } t_state;

    typedef enum logic [1:0] {
        SH_ROW,
        SH_COL,
        SH_P
    } t_share;

    typedef struct packed {
        logic [LVL_W-1:0]  lvl;
        logic [IDX_W-1:0]  node;
        logic [1:0]        child;
        logic [1:0]        cap_idx;
        t_share            share;
        logic              rd_own;
        logic              rd_child;
        logic              acc_en;
        logic              acc_first;
        logic              sum_wr;
        logic              cap_own;
        logic              cap_b;
        logic              add;
        logic              mul;
        logic              div;
        logic              clamp;
        logic              cnt_wr;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_status;

    typedef struct packed {
        logic              en;
        logic [PIX_W-1:0]  addr;
        logic [SMP_W-1:0]  data;
    } t_load_wr;

    // First entry of level lvl in the node store (level 1 holds 2x2 blocks).
    function automatic logic [NODE_W-1:0] level_base(input logic [LVL_W-1:0] lvl);
        logic [NODE_W:0] acc;
        acc = '0;
        for (int i = 1; i < LOG_SIDE; i++) begin
            if (LVL_W'(i) < lvl) begin
                acc = acc + ((NODE_W + 1)'(1) << (2 * (LOG_SIDE - i)));
            end
        end
        return acc[NODE_W-1:0];
    endfunction

    // Index of the last node of level lvl.
    function automatic logic [IDX_W-1:0] node_last(input logic [LVL_W-1:0] lvl);
        logic [IDX_W:0] cnt;
        cnt = (IDX_W + 1)'(1) << (2 * (LOG_SIDE - int'(lvl)));
        return IDX_W'(cnt - (IDX_W + 1)'(1));
    endfunction

    // Raster index to Z-order index, x in the even bits.
    function automatic logic [PIX_W-1:0] morton(input logic [PIX_W-1:0] raster);
        logic [PIX_W-1:0] m;
        m = '0;
        for (int i = 0; i < LOG_SIDE; i++) begin
            m[2*i]     = raster[i];
            m[2*i + 1] = raster[LOG_SIDE + i];
        end
        return m;
    endfunction

endpackage

// File: src/qtd_ctrl.sv
// ----------------------------------------------------------------------------
// qtd_ctrl
// Sequencer of the pyramid build and the count distribution pass.
// ----------------------------------------------------------------------------
module qtd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  qtd_pkg::t_status  i_status,
    output qtd_pkg::t_cmd     o_cmd,
    output logic              o_busy,
    output logic              o_pass_done
);
    import qtd_pkg::*;

    t_state              r_state, n_state;
    logic [LVL_W-1:0]    r_lvl, n_lvl;
    logic [IDX_W-1:0]    r_node, n_node;
    logic [STEP_W-1:0]   r_step, n_step;
    t_share              r_share, n_share;
    logic                w_node_last;

    assign w_node_last = (r_node == node_last(r_lvl));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lvl   <= '0;
            r_node  <= '0;
            r_step  <= '0;
            r_share <= SH_ROW;
        end else begin
            r_state <= n_state;
            r_lvl   <= n_lvl;
            r_node  <= n_node;
            r_step  <= n_step;
            r_share <= n_share;
        end
    end

    // Next state and counters
    always_comb begin
        n_state = r_state;
        n_lvl   = r_lvl;
        n_node  = r_node;
        n_step  = r_step;
        n_share = r_share;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_B_STEP;
                    n_lvl   = LVL_W'(1);
                    n_node  = '0;
                    n_step  = '0;
                end
            end
            S_B_STEP: begin
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(4)) begin
                    n_step = '0;
                    if (w_node_last) begin
                        n_node = '0;
                        if (r_lvl == LVL_W'(LOG_SIDE)) begin
                            n_state = S_D_READ;
                        end else begin
                            n_lvl = r_lvl + 1'b1;
                        end
                    end else begin
                        n_node = r_node + 1'b1;
                    end
                end
            end
            S_D_READ: begin
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(5)) begin
                    n_step  = '0;
                    n_state = S_D_ADD;
                end
            end
            S_D_ADD: begin
                n_state = S_D_MUL;
                n_share = SH_ROW;
            end
            S_D_MUL: begin
                n_state = S_D_DIV;
            end
            S_D_DIV: begin
                if (i_status.div_done) begin
                    if (r_share == SH_P) begin
                        n_state = S_D_CLAMP;
                    end else begin
                        n_share = (r_share == SH_ROW) ? SH_COL : SH_P;
                        n_state = S_D_MUL;
                    end
                end
            end
            S_D_CLAMP: begin
                n_state = S_D_WRITE;
                n_step  = '0;
            end
            S_D_WRITE: begin
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(3)) begin
                    n_step = '0;
                    if (w_node_last) begin
                        n_node = '0;
                        if (r_lvl == LVL_W'(1)) begin
                            n_state = S_IDLE;
                        end else begin
                            n_lvl   = r_lvl - 1'b1;
                            n_state = S_D_READ;
                        end
                    end else begin
                        n_node  = r_node + 1'b1;
                        n_state = S_D_READ;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd         = '0;
        o_cmd.lvl     = r_lvl;
        o_cmd.node    = r_node;
        o_cmd.share   = r_share;
        o_pass_done   = 1'b0;
        unique case (r_state)
            S_B_STEP: begin
                o_cmd.child     = r_step[1:0];
                o_cmd.rd_child  = (r_step < STEP_W'(4));
                o_cmd.acc_en    = (r_step >= STEP_W'(1)) && (r_step <= STEP_W'(3));
                o_cmd.acc_first = (r_step == STEP_W'(1));
                o_cmd.sum_wr    = (r_step == STEP_W'(4));
            end
            S_D_READ: begin
                o_cmd.rd_own   = (r_step == '0);
                o_cmd.cap_own  = (r_step == STEP_W'(1));
                o_cmd.rd_child = (r_step >= STEP_W'(1)) && (r_step <= STEP_W'(4));
                o_cmd.child    = 2'(r_step - STEP_W'(1));
                o_cmd.cap_b    = (r_step >= STEP_W'(2));
                o_cmd.cap_idx  = 2'(r_step - STEP_W'(2));
            end
            S_D_ADD:   o_cmd.add   = 1'b1;
            S_D_MUL:   o_cmd.mul   = 1'b1;
            S_D_DIV:   o_cmd.div   = 1'b1;
            S_D_CLAMP: o_cmd.clamp = 1'b1;
            S_D_WRITE: begin
                o_cmd.cnt_wr = 1'b1;
                o_cmd.child  = r_step[1:0];
                o_pass_done  = (r_step == STEP_W'(3)) && w_node_last
                               && (r_lvl == LVL_W'(1));
            end
            S_IDLE: ;
            default: ;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// File: src/qtd_datapath.sv
// ----------------------------------------------------------------------------
// qtd_datapath
// Sample, sum, count and pixel stores with the share divider and clamp.
// ----------------------------------------------------------------------------
module qtd_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  qtd_pkg::t_cmd               i_cmd,
    output qtd_pkg::t_status            o_status,
    input  qtd_pkg::t_load_wr           i_ld,
    input  logic                        i_map_rd_en,
    input  logic [qtd_pkg::PIX_W-1:0]   i_map_rd_addr,
    output logic                        o_map_q
);
    import qtd_pkg::*;

    logic [SMP_W-1:0]  r_smp_mem [NPIX];
    logic [SUM_W-1:0]  r_sum_mem [NODES];
    logic [CNT_W-1:0]  r_cnt_mem [NODES];
    logic              r_map_mem [NPIX];

    logic [SMP_W-1:0]  r_smp_q;
    logic [SUM_W-1:0]  r_sum_q;
    logic [CNT_W-1:0]  r_cnt_q;
    logic              r_map_q;

    logic [SUM_W-1:0]  r_acc;
    logic [SUM_W-1:0]  r_t;
    logic [CNT_W-1:0]  r_n;
    logic [SUM_W-1:0]  r_b [4];
    logic [SUM_W-1:0]  r_ba, r_bb;
    logic [NUM_W-1:0]  r_rem, r_dvs;
    logic [CNT_W-1:0]  r_q;
    logic [DCNT_W-1:0] r_dcnt;
    logic [CNT_W-1:0]  r_rowq, r_colq, r_p;
    logic [CNT_W-1:0]  r_kid [4];

    logic              w_leaf;
    logic [PIX_W-1:0]  w_child_pix;
    logic [NODE_W-1:0] w_own_addr, w_child_addr;
    logic [SUM_W-1:0]  w_child_data;
    logic [SUM_W-1:0]  w_bsel;
    logic [NUM_W-1:0]  w_prod;
    logic              w_ge;
    logic [CNT_W-1:0]  w_qnext, w_qfin;
    logic              w_div_done;
    logic [CNT_W:0]    w_rq, w_cq, w_pq, w_nn, w_lim, w_p1, w_s;
    logic [CNT_W-1:0]  w_root_n;
    logic [SUM_W:0]    w_root_sum;

    assign w_leaf       = (i_cmd.lvl == LVL_W'(1));
    assign w_child_pix  = {i_cmd.node, i_cmd.child};
    assign w_own_addr   = NODE_W'(level_base(i_cmd.lvl) + NODE_W'(i_cmd.node));
    assign w_child_addr = NODE_W'((PIX_W + 1)'(level_base(i_cmd.lvl - 1'b1))
                                  + (PIX_W + 1)'(w_child_pix));
    assign w_child_data = w_leaf ? SUM_W'(r_smp_q) : r_sum_q;

    // Root count: round half up of total over full scale
    assign w_root_sum = (SUM_W + 1)'(r_sum_q) + (SUM_W + 1)'(BIAS);
    assign w_root_n   = CNT_W'(w_root_sum >> ROUND_SH);

    // Sample store
    always_ff @(posedge i_clk) begin
        if (i_ld.en) begin
            r_smp_mem[i_ld.addr] <= i_ld.data;
        end
        if (i_cmd.rd_child && w_leaf) begin
            r_smp_q <= r_smp_mem[w_child_pix];
        end
    end

    // Block sum store
    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_wr) begin
            r_sum_mem[w_own_addr] <= r_acc + w_child_data;
        end
        if (i_cmd.rd_own) begin
            r_sum_q <= r_sum_mem[w_own_addr];
        end else if (i_cmd.rd_child && !w_leaf) begin
            r_sum_q <= r_sum_mem[w_child_addr];
        end
    end

    // Node count store
    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_wr && !w_leaf) begin
            r_cnt_mem[w_child_addr] <= r_kid[i_cmd.child];
        end
        if (i_cmd.rd_own) begin
            r_cnt_q <= r_cnt_mem[w_own_addr];
        end
    end

    // Pixel store
    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_wr && w_leaf) begin
            r_map_mem[w_child_pix] <= (r_kid[i_cmd.child] != '0);
        end
        if (i_map_rd_en) begin
            r_map_q <= r_map_mem[i_map_rd_addr];
        end
    end

    assign o_map_q = r_map_q;

    // Share divider: restoring, one quotient bit per cycle
    always_comb begin
        case (i_cmd.share)
            SH_ROW:  w_bsel = r_ba;
            SH_COL:  w_bsel = r_bb;
            default: w_bsel = r_b[0];
        endcase
    end

    assign w_prod     = NUM_W'(r_n) * NUM_W'(w_bsel);
    assign w_ge       = (r_rem >= r_dvs);
    assign w_qnext    = {r_q[CNT_W-2:0], w_ge};
    assign w_qfin     = (r_t == '0) ? '0 : w_qnext;
    assign w_div_done = i_cmd.div && (r_dcnt == DCNT_W'(DIV_STEPS - 1));
    assign o_status.div_done = w_div_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.mul) begin
            r_dcnt <= '0;
        end else if (i_cmd.div) begin
            r_dcnt <= r_dcnt + 1'b1;
        end
    end

    // Clamp of the first child's share
    always_comb begin
        w_rq  = (CNT_W + 1)'(r_rowq);
        w_cq  = (CNT_W + 1)'(r_colq);
        w_pq  = (CNT_W + 1)'(r_p);
        w_nn  = (CNT_W + 1)'(r_n);
        w_lim = (w_rq < w_cq) ? w_rq : w_cq;
        w_p1  = (w_pq > w_lim) ? w_lim : w_pq;
        w_s   = w_rq + w_cq;
        if ((w_s > w_nn) && (w_p1 < w_s - w_nn)) begin
            w_p1 = w_s - w_nn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_en) begin
            r_acc <= i_cmd.acc_first ? w_child_data : r_acc + w_child_data;
        end
        if (i_cmd.cap_own) begin
            r_t <= r_sum_q;
            r_n <= (i_cmd.lvl == LVL_W'(LOG_SIDE)) ? w_root_n : r_cnt_q;
        end
        if (i_cmd.cap_b) begin
            r_b[i_cmd.cap_idx] <= w_child_data;
        end
        if (i_cmd.add) begin
            r_ba <= r_b[0] + r_b[1];
            r_bb <= r_b[0] + r_b[2];
        end
        if (i_cmd.mul) begin
            r_rem <= (w_prod << 1) + NUM_W'(r_t);
            r_dvs <= NUM_W'({r_t, 1'b0}) << (DIV_STEPS - 1);
            r_q   <= '0;
        end else if (i_cmd.div) begin
            r_rem <= w_ge ? r_rem - r_dvs : r_rem;
            r_dvs <= r_dvs >> 1;
            r_q   <= w_qnext;
        end
        if (w_div_done) begin
            case (i_cmd.share)
                SH_ROW:  r_rowq <= w_qfin;
                SH_COL:  r_colq <= w_qfin;
                default: r_p    <= w_qfin;
            endcase
        end
        if (i_cmd.clamp) begin
            r_kid[0] <= CNT_W'(w_p1);
            r_kid[1] <= CNT_W'(w_rq - w_p1);
            r_kid[2] <= CNT_W'(w_cq - w_p1);
            r_kid[3] <= CNT_W'(w_nn + w_p1 - w_rq - w_cq);
        end
    end

endmodule

// File: src/quadtree_dither.sv
// ----------------------------------------------------------------------------
// quadtree_dither
// Quadtree dither of a 64 by 64 grey image: load, distribute, read out.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | i_valid / o_ready    | i_command, i_in_sample
//  result   | o_valid / i_ready    | o_out_on, o_out_last, o_out_ready
//
//  A load item writes its sample when taken; a fetch item's result appears in
//  the output register on the next cycle, so both sustain one item per cycle
//  while no pass runs and, for fetches, results are drained. The last load of
//  an image starts the pyramid pass, during which no item is taken: it builds
//  the sums of all 1365 nodes, then splits the counts over them, chiefly by
//  three share divisions per node. Reset leaves no image ready. A stalled
//  result holds its register; a fetch is taken only when that register is
//  empty or being drained.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quadtree_dither (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_command,
    input  logic signed [qtd_pkg::SMP_W-1:0]  i_in_sample,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_out_on,
    output logic                              o_out_last,
    output logic                              o_out_ready
);
    import qtd_pkg::*;

    logic [PIX_W-1:0]         r_load_idx;
    logic [PIX_W-1:0]         r_read_idx;
    logic                     r_done;
    logic                     r_o_valid;
    logic                     r_o_done;
    logic                     r_o_last;

    logic                     w_busy;
    logic                     w_pass_done;
    logic                     w_acc, w_acc_load, w_acc_fetch;
    logic                     w_start;
    logic                     w_map_q;
    logic signed [SMP_W-1:0]  w_sat;
    t_load_wr                 w_ld;
    t_cmd                     w_cmd;
    t_status                  w_status;

    // Take an item unless the pass runs; a fetch also needs room for its result
    assign o_ready     = !w_busy && (!i_command || !r_o_valid || i_ready);
    assign w_acc       = i_valid && o_ready;
    assign w_acc_load  = w_acc && !i_command;
    assign w_acc_fetch = w_acc && i_command;
    assign w_start     = w_acc_load && (r_load_idx == PIX_W'(NPIX - 1));

    // Saturate, bias to 0..32768 and store in Z order
    always_comb begin
        w_sat = i_in_sample;
        if (i_in_sample > SMP_W'(BIAS)) begin
            w_sat = SMP_W'(BIAS);
        end else if (i_in_sample < -SMP_W'(BIAS)) begin
            w_sat = -SMP_W'(BIAS);
        end
        w_ld.en   = w_acc_load;
        w_ld.addr = morton(r_load_idx);
        w_ld.data = SMP_W'(w_sat + SMP_W'(BIAS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_idx <= '0;
            r_read_idx <= '0;
            r_done     <= 1'b0;
            r_o_valid  <= 1'b0;
            r_o_done   <= 1'b0;
            r_o_last   <= 1'b0;
        end else begin
            // A load advances the raster and drops any finished image
            if (w_acc_load) begin
                r_load_idx <= r_load_idx + 1'b1;
                r_done     <= 1'b0;
            end
            if (w_pass_done) begin
                r_done     <= 1'b1;
                r_read_idx <= '0;
            end
            // A fetch fills the output register; an unready image reads as zero
            if (w_acc_fetch) begin
                r_o_valid <= 1'b1;
                r_o_done  <= r_done;
                r_o_last  <= r_done && (r_read_idx == PIX_W'(NPIX - 1));
                if (r_done) begin
                    r_read_idx <= r_read_idx + 1'b1;
                end
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_o_valid;
    assign o_out_on    = r_o_done && w_map_q;
    assign o_out_last  = r_o_last;
    assign o_out_ready = r_o_done;

    qtd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_busy      (w_busy),
        .o_pass_done (w_pass_done)
    );

    qtd_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_ld          (w_ld),
        .i_map_rd_en   (w_acc_fetch),
        .i_map_rd_addr (morton(r_read_idx)),
        .o_map_q       (w_map_q)
    );

    `QTD_ASSERT(a_fetch_gives_item, i_clk, i_rst_n, (i_valid && o_ready && i_command) |=> o_valid, "fetch item produced no result")
    `QTD_ASSERT(a_busy_blocks_input, i_clk, i_rst_n, w_busy |-> !o_ready, "item taken during pyramid pass")
    `QTD_ASSERT(a_last_in_image, i_clk, i_rst_n, (o_valid && o_out_last) |-> o_out_ready, "last pixel flagged outside an image")
    `QTD_ASSERT(a_pass_sets_done, i_clk, i_rst_n, w_pass_done |=> r_done, "pass end did not mark image ready")
    `QTD_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid, "result held across reset")

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the quadtree dither block. Loads whole images
// (random, ramp, all black, with out-of-range samples), fetches the dithered
// raster with wrap-around and early fetches, and compares every result item
// against an in-bench quadtree predictor. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qtd_pkg::SIDE;
    import qtd_pkg::NPIX;

    localparam int WATCHDOG_LIMIT = 400000;
    localparam int BIAS_VAL       = 16384;

    typedef enum bit {CMD_LOAD = 1'b0, CMD_FETCH = 1'b1} t_cmd_code;

    typedef struct {
        t_cmd_code          cmd;
        logic signed [15:0] smp;
    } t_item;

    typedef struct {
        bit on;
        bit last;
        bit rdy;
    } t_pixel;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               i_command = 1'b0;
    logic signed [15:0] i_in_sample = '0;
    logic               i_ready = 1'b0;
    logic               o_ready, o_valid, o_out_on, o_out_last, o_out_ready;

    quadtree_dither uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_command   (i_command),
        .i_in_sample (i_in_sample),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_on    (o_out_on),
        .o_out_last  (o_out_last),
        .o_out_ready (o_out_ready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: own copy of the image, the dithered map and the indices
    // ------------------------------------------------------------------
    int     grey_img [NPIX];
    bit     dot_map  [NPIX];
    int     load_pos;
    int     read_pos;
    bit     img_ready;
    t_pixel pixel_queue[$];
    t_item  pending_items[$];
    int     errors;

    function automatic longint unsigned block_total(int x, int y, int s);
        int h;
        if (s <= 1)
            return longint'(grey_img[y * SIDE + x] + BIAS_VAL);
        h = s / 2;
        return block_total(x, y, h) + block_total(x + h, y, h)
             + block_total(x, y + h, h) + block_total(x + h, y + h, h);
    endfunction

    // Half-up rounded share n*b/t
    function automatic longint unsigned round_share(longint unsigned n,
                                                    longint unsigned b,
                                                    longint unsigned t);
        return (2 * n * b + t) / (2 * t);
    endfunction

    function automatic void split_count(int x, int y, int s, longint unsigned n);
        int h;
        longint unsigned b0, b1, b2, b3, t, rq, cq, p, lim;
        if (s <= 1) begin
            dot_map[y * SIDE + x] = (n > 0);
            return;
        end
        h  = s / 2;
        b0 = block_total(x, y, h);
        b1 = block_total(x + h, y, h);
        b2 = block_total(x, y + h, h);
        b3 = block_total(x + h, y + h, h);
        t  = b0 + b1 + b2 + b3;
        rq = 0; cq = 0; p = 0;
        if (t != 0) begin
            rq = round_share(n, b0 + b1, t);
            cq = round_share(n, b0 + b2, t);
            p  = round_share(n, b0, t);
        end
        lim = (rq < cq) ? rq : cq;
        if (p > lim)
            p = lim;
        // keep the bottom-right share non-negative
        if (rq + cq > n && p < rq + cq - n)
            p = rq + cq - n;
        split_count(x, y, h, p);
        split_count(x + h, y, h, rq - p);
        split_count(x, y + h, h, cq - p);
        split_count(x + h, y + h, h, n + p - rq - cq);
    endfunction

    function automatic void dither_frame();
        longint unsigned den, total, n;
        int s;
        den = 32768;
        s   = SIDE;
        while (s > 1) begin
            s   = s / 2;
            den = den * 4;
        end
        total = block_total(0, 0, SIDE);
        n = (2 * total * longint'(NPIX) + den) / (2 * den);
        split_count(0, 0, SIDE, n);
    endfunction

    function automatic void predict_item(t_cmd_code cmd, logic signed [15:0] smp);
        int v;
        t_pixel px;
        if (cmd == CMD_LOAD) begin
            v = smp;
            if (v > BIAS_VAL)  v = BIAS_VAL;
            if (v < -BIAS_VAL) v = -BIAS_VAL;
            img_ready = 1'b0;
            grey_img[load_pos] = v;
            load_pos++;
            if (load_pos >= NPIX) begin
                dither_frame();
                load_pos  = 0;
                read_pos  = 0;
                img_ready = 1'b1;
            end
            return;
        end
        if (!img_ready) begin
            px = '{0, 0, 0};
        end else begin
            px.on   = dot_map[read_pos];
            px.last = (read_pos == NPIX - 1);
            px.rdy  = 1'b1;
            read_pos = (read_pos + 1) % NPIX;
        end
        pixel_queue.push_back(px);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void add_item(t_cmd_code cmd, int smp);
        t_item it;
        it.cmd = cmd;
        it.smp = 16'(smp);
        pending_items.push_back(it);
    endfunction

    function automatic void add_fetches(int count);
        for (int k = 0; k < count; k++)
            add_item(CMD_FETCH, $urandom());
    endfunction

    // Load the rest of an image; style 0 random, 1 ramp plus noise, 2 all black
    function automatic void add_frame(int first, int style);
        int v;
        for (int k = first; k < NPIX; k++) begin
            case (style)
                0: begin
                    if ($urandom_range(0, 19) == 0)
                        v = $urandom_range(0, 65535);   // any 16-bit pattern
                    else
                        v = $urandom_range(0, 2 * BIAS_VAL) - BIAS_VAL;
                end
                1: begin
                    v = ((k % SIDE) * 512) - BIAS_VAL + $urandom_range(0, 255);
                end
                default: begin
                    v = -BIAS_VAL;
                end
            endcase
            add_item(CMD_LOAD, v);
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: bursts with random gaps, payload held until accepted
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;
    int accepted_in;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                predict_item(t_cmd_code'(i_command), i_in_sample);
                accepted_in++;
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    i_command   <= pending_items[0].cmd;
                    i_in_sample <= pending_items[0].smp;
                    void'(pending_items.pop_front());
                    i_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        // long bursts now and then give stretches with no idling
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                                                 : $urandom_range(1, 12);
                        gap_left   = $urandom_range(0, 4);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random stall pattern, one long hold-off, field checks
    // ------------------------------------------------------------------
    int     stall_mode  = 0;
    int     mode_cycles = 0;
    int     hold_left   = 0;
    bit     hold_done   = 1'b0;
    int     pixels_seen = 0;
    t_pixel want;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                pixels_seen++;
                if (pixel_queue.size() == 0) begin
                    $display("%0t: unexpected result item on=%0b last=%0b ready=%0b",
                             $time, o_out_on, o_out_last, o_out_ready);
                    errors++;
                end else begin
                    want = pixel_queue.pop_front();
                    if (o_out_on !== want.on || o_out_last !== want.last ||
                        o_out_ready !== want.rdy) begin
                        $display("%0t: mismatch expected on=%0b last=%0b ready=%0b, got on=%0b last=%0b ready=%0b",
                                 $time, want.on, want.last, want.rdy,
                                 o_out_on, o_out_last, o_out_ready);
                        errors++;
                    end
                end
            end
            // one long hold-off once the image reads back, to back up the input
            if (!hold_done && pixels_seen >= 150) begin
                hold_done = 1'b1;
                hold_left = 500;
            end
            if (mode_cycles == 0) begin
                stall_mode  = $urandom_range(0, 2);
                mode_cycles = $urandom_range(50, 400);
            end else begin
                mode_cycles--;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                case (stall_mode)
                    0: i_ready <= 1'b1;
                    1: i_ready <= ($urandom_range(0, 3) != 0);
                    default: i_ready <= ($urandom_range(0, 1) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles with no item accepted on either channel
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: fill the queue, reset, drain, report
    // ------------------------------------------------------------------
    initial begin
        errors      = 0;
        accepted_in = 0;
        load_pos    = 0;
        read_pos    = 0;
        img_ready   = 1'b0;
        foreach (grey_img[k]) grey_img[k] = 0;
        foreach (dot_map[k])  dot_map[k]  = 1'b0;

        // Directed: early fetches, extreme and out-of-range samples
        add_fetches(3);
        add_item(CMD_LOAD, 32767);
        add_item(CMD_LOAD, -32768);
        add_item(CMD_LOAD, 16385);
        add_item(CMD_LOAD, -16385);
        add_item(CMD_LOAD, 16384);
        add_item(CMD_LOAD, -16384);
        add_item(CMD_LOAD, 0);
        add_item(CMD_LOAD, 16'h5555);
        add_item(CMD_LOAD, 16'hAAAA);
        add_fetches(2);                        // fetch during a load
        add_frame(9, 0);
        add_fetches(NPIX + 40);                // read all, wrap around

        // A new load voids the image; fetch must then come back empty
        add_item(CMD_LOAD, -16384);
        add_fetches(4);
        add_frame(1, 2);                       // all black: zero divisors
        add_fetches(300);

        add_frame(0, 1);                       // ramp
        add_fetches(NPIX + 10);

        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() > 0 || i_valid) @(posedge i_clk);
        while (pixel_queue.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
